FILE: hdl/max_level_request_voter_top_macros.svh
// Assertion helpers for the level voter checker.
`ifndef MAX_LEVEL_REQUEST_VOTER_TOP_MACROS_SVH
`define MAX_LEVEL_REQUEST_VOTER_TOP_MACROS_SVH

// Sampled on clk, off while reset is asserted.
`define MLRV_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Sampled on clk, also checked while reset is asserted.
`define MLRV_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: hdl/mlrv_pkg.sv
package mlrv_pkg;

	localparam int LEVELS = 4;
	localparam int LVL_W  = 2;
	localparam int ID_W   = 4;
	localparam int AID_W  = 3;

	localparam logic [LVL_W-1:0] LVL_COLD = '0;
	localparam logic [LVL_W-1:0] LVL_MAX  = LVL_W'(LEVELS - 1);

	typedef enum logic [1:0] {
		FUNC_REGISTER = 2'd0,
		FUNC_SUBMIT   = 2'd1,
		FUNC_POLL     = 2'd2,
		FUNC_READ     = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	// operation held in the input register
	typedef struct packed {
		logic              valid;
		func_t             func;
		logic [ID_W-1:0]   slot;
		logic              in_range;
		logic [LVL_W-1:0]  level;
	} op_t;

	// one result word
	typedef struct packed {
		status_t           status;
		logic [AID_W-1:0]  assigned_id;
		logic [LVL_W-1:0]  level;
		logic              seen;
	} res_t;

endpackage

FILE: hdl/mlrv_decode.sv
module mlrv_decode #(
	parameter int CLIENTS = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       accept,
	input  logic [1:0]                 func,
	input  logic [mlrv_pkg::ID_W-1:0]  task_id,
	input  logic [mlrv_pkg::LVL_W-1:0] requested_level,
	output mlrv_pkg::op_t              op_s1
);

	logic [mlrv_pkg::LVL_W-1:0] level_sat;
	logic                       in_range;

	// out-of-range requests clamp to the hottest level
	assign level_sat = (requested_level > mlrv_pkg::LVL_MAX) ? mlrv_pkg::LVL_MAX
	                                                        : requested_level;
	assign in_range  = (32'(task_id) < CLIENTS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1 <= '0;
		end else begin
			op_s1.valid <= accept;
			if (accept) begin
				op_s1.func     <= mlrv_pkg::func_t'(func);
				op_s1.slot     <= task_id;
				op_s1.in_range <= in_range;
				op_s1.level    <= level_sat;
			end
		end
	end

endmodule

FILE: hdl/mlrv_state.sv
module mlrv_state #(
	parameter int CLIENTS = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  mlrv_pkg::op_t op_s1,
	output logic          done_q,
	output mlrv_pkg::res_t res_q
);

	localparam int IDX_W = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
	localparam int CNT_W = $clog2(CLIENTS + 1);

	logic [mlrv_pkg::LVL_W-1:0] levels_q [CLIENTS];
	logic [mlrv_pkg::LVL_W-1:0] levels_nxt [CLIENTS];
	logic [mlrv_pkg::LVL_W-1:0] sys_q, sys_nxt, hot;
	logic [CLIENTS-1:0]         flags_q, flags_nxt;
	logic [CNT_W-1:0]           count_q, count_nxt;
	logic [mlrv_pkg::LEVELS-1:0] present;
	logic [IDX_W-1:0]           idx;
	mlrv_pkg::res_t             res_nxt;

	assign idx = IDX_W'(op_s1.slot);

	always_comb begin
		levels_nxt = levels_q;
		sys_nxt    = sys_q;
		flags_nxt  = flags_q;
		count_nxt  = count_q;
		res_nxt.status      = mlrv_pkg::ST_OK;
		res_nxt.assigned_id = '0;
		res_nxt.seen        = 1'b0;

		if (op_s1.func == mlrv_pkg::FUNC_SUBMIT && op_s1.in_range) begin
			levels_nxt[idx] = op_s1.level;
		end

		// one presence bit per level, then the highest level present wins
		for (int l = 0; l < mlrv_pkg::LEVELS; l++) begin
			present[l] = 1'b0;
			for (int c = 0; c < CLIENTS; c++) begin
				if (levels_nxt[c] == mlrv_pkg::LVL_W'(l)) begin
					present[l] = 1'b1;
				end
			end
		end
		hot = mlrv_pkg::LVL_COLD;
		for (int l = 0; l < mlrv_pkg::LEVELS; l++) begin
			if (present[l]) begin
				hot = mlrv_pkg::LVL_W'(l);
			end
		end

		case (op_s1.func)
			mlrv_pkg::FUNC_REGISTER: begin
				if (count_q < CNT_W'(CLIENTS)) begin
					res_nxt.assigned_id = mlrv_pkg::AID_W'(count_q);
					count_nxt = count_q + CNT_W'(1);
				end else begin
					res_nxt.status = mlrv_pkg::ST_FULL;
				end
			end
			mlrv_pkg::FUNC_SUBMIT: begin
				if (!op_s1.in_range) begin
					res_nxt.status = mlrv_pkg::ST_RANGE;
				end else if (hot != sys_q) begin
					sys_nxt      = hot;
					flags_nxt    = '1;
					res_nxt.seen = 1'b1;
				end
			end
			mlrv_pkg::FUNC_POLL: begin
				if (!op_s1.in_range) begin
					res_nxt.status = mlrv_pkg::ST_RANGE;
				end else begin
					res_nxt.seen   = flags_q[idx];
					flags_nxt[idx] = 1'b0;
				end
			end
			mlrv_pkg::FUNC_READ: begin
			end
			default: begin
			end
		endcase

		res_nxt.level = sys_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CLIENTS; c++) begin
				levels_q[c] <= mlrv_pkg::LVL_COLD;
			end
			sys_q   <= mlrv_pkg::LVL_COLD;
			flags_q <= '0;
			count_q <= '0;
			done_q  <= 1'b0;
			res_q   <= '0;
		end else begin
			done_q <= op_s1.valid;
			if (op_s1.valid) begin
				levels_q <= levels_nxt;
				sys_q    <= sys_nxt;
				flags_q  <= flags_nxt;
				count_q  <= count_nxt;
				res_q    <= res_nxt;
			end
		end
	end

endmodule

FILE: hdl/max_level_request_voter_top.sv
// Max-level request voter. Up to CLIENTS clients each hold a requested level
// (0 coldest, 3 hottest); the system level is the hottest request. A command
// word (func, task_id, requested_level) is taken on any clock edge where start
// is high; busy is never raised, so one word per cycle is sustained. Each
// command yields exactly one result word, shown for a single cycle with done
// high, after the input and result registers. The receiver cannot stall: a
// result not captured in its done cycle is gone. The figure of one word per
// cycle comes from the client table, the level maximum and the change flags
// all being updated in one pass between the input register and the result
// register, so each command sees everything its predecessor left behind.
// Register (func 0) hands out slots 0, 1, 2... and then reports table full;
// submit (1) stores a level and, when the maximum moves, flags every slot;
// poll (2) returns and clears a slot's change flag; read (3) only reports.
// A task_id at or above CLIENTS on submit or poll returns status 2 and does
// nothing. Every result carries the level as it stands after the command.
module max_level_request_voter_top #(
	parameter int CLIENTS = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] func,
	input  logic [3:0] task_id,
	input  logic [1:0] requested_level,
	output logic       done,
	output logic [1:0] status,
	output logic [2:0] assigned_id,
	output logic [1:0] current_level,
	output logic       change_seen
);

	mlrv_pkg::op_t  op_s1;
	mlrv_pkg::res_t res_q;
	logic           accept;

	// every command finishes in one pass, so the block is always ready
	assign busy   = 1'b0;
	assign accept = start & ~busy;

	// input register: decoded command, clamped level, slot range check
	mlrv_decode #(
		.CLIENTS(CLIENTS)
	) u_decode (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.func           (func),
		.task_id        (task_id),
		.requested_level(requested_level),
		.op_s1          (op_s1)
	);

	// client table, maximum, flags and result register
	mlrv_state #(
		.CLIENTS(CLIENTS)
	) u_state (
		.clk   (clk),
		.arst_n(arst_n),
		.op_s1 (op_s1),
		.done_q(done),
		.res_q (res_q)
	);

	assign status        = res_q.status;
	assign assigned_id   = res_q.assigned_id;
	assign current_level = res_q.level;
	assign change_seen   = res_q.seen;

endmodule

FILE: hdl/mlrv_checker.sv
`include "max_level_request_voter_top_macros.svh"

module mlrv_checker #(
	parameter int CLIENTS = 8
) (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic [1:0] func,
	input logic [3:0] task_id,
	input logic       done,
	input logic [1:0] status,
	input logic [1:0] current_level,
	input logic       change_seen
);

	logic acc;
	logic bad_slot;
	logic range_st;

	assign acc      = start && !busy;
	assign bad_slot = acc && (32'(task_id) >= CLIENTS) &&
	                  (func == mlrv_pkg::FUNC_SUBMIT || func == mlrv_pkg::FUNC_POLL);
	assign range_st = (status == mlrv_pkg::ST_RANGE);

	// each accepted word gives its result after the input and result registers
	`MLRV_ASSERT(a_result_follows, acc |-> ##2 done, "missing result word")
	`MLRV_ASSERT(a_no_stray_result, done |-> $past(acc, 2), "result without command")
	// out-of-range slot on submit or poll reports range status
	`MLRV_ASSERT(a_range_status, done && $past(bad_slot, 2) |-> range_st, "range status expected")
	// a level move is only ever reported by the submit that caused it
	`MLRV_ASSERT(a_move_seen, done && $changed(current_level) |-> change_seen, "unflagged move")
	`MLRV_ASSERT_ALWAYS(a_quiet_in_reset, !arst_n |=> !done, "result during reset")

endmodule

bind max_level_request_voter_top mlrv_checker #(.CLIENTS(CLIENTS)) u_mlrv_checker (.*);
